// File: design/repeat_pulse_generator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the repeat pulse generator
// Clocked check helpers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef REPEAT_PULSE_GENERATOR_TOP_ASSERT_SVH
`define REPEAT_PULSE_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define RPG_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("same-cycle check failed");
`define RPG_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next-cycle check failed");
`else
`define RPG_ASSERT_SAME(label, cond, expr)
`define RPG_ASSERT_NEXT(label, cond, expr)
`endif

`endif

// File: design/rpg_pkg.sv
// ---------------------------------------------------------------------------
// Repeat pulse generator package
// Shared types, codes and stream layout constants.
// ---------------------------------------------------------------------------
package rpg_pkg;

  localparam int CFG_W       = 16;
  localparam int ELAPSED_W   = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  localparam logic [1:0] ARM_RUN     = 2'd0;
  localparam logic [1:0] ARM_STOP    = 2'd1;
  localparam logic [1:0] ARM_RELEASE = 2'd2;

  localparam logic [1:0] REG_ON_DURATION  = 2'd0;
  localparam logic [1:0] REG_OFF_DURATION = 2'd1;
  localparam logic [1:0] REG_PULSE_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    MODE_RUN     = 3'b001,
    MODE_STOP    = 3'b010,
    MODE_RELEASE = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    PIN_OFF  = 2'd0,
    PIN_ON   = 2'd1,
    PIN_FREE = 2'd2
  } pin_t;

  typedef struct packed {
    logic [CFG_W-1:0] on_duration;
    logic [CFG_W-1:0] off_duration;
    logic [CFG_W-1:0] pulse_count;
  } cfg_t;

endpackage

// File: design/rpg_core.sv
// ---------------------------------------------------------------------------
// Repeat pulse generator core
// Holds the pulse timer state and computes the next state and status.
// ---------------------------------------------------------------------------
module rpg_core #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          operation,
  input  logic [rpg_pkg::ELAPSED_W-1:0] elapsed,
  input  logic [1:0]                    arm_mode,
  input  rpg_pkg::cfg_t                 cfg,
  output rpg_pkg::pin_t                 pin_status,
  output logic                          running
);
  import rpg_pkg::*;

  logic [TIME_BITS:0]    remaining_time;
  logic [TIME_BITS:0]    remaining_time_next;
  logic [COUNT_BITS-1:0] pulses_left;
  logic [COUNT_BITS-1:0] pulses_left_next;
  mode_t                 mode;
  mode_t                 mode_next;
  pin_t                  pin_state;
  pin_t                  pin_state_next;

  logic [TIME_BITS:0] dt_ext;
  logic [TIME_BITS:0] on_ext;
  logic [TIME_BITS:0] off_ext;
  logic [TIME_BITS:0] reload;
  logic [TIME_BITS:0] rem_dec;

  assign dt_ext  = {1'b0, TIME_BITS'(elapsed)};
  assign on_ext  = {1'b0, TIME_BITS'(cfg.on_duration)};
  assign off_ext = {1'b0, TIME_BITS'(cfg.off_duration)};
  assign reload  = on_ext + off_ext;
  assign rem_dec = (remaining_time > dt_ext) ? (remaining_time - dt_ext) : '0;

  always_comb begin
    remaining_time_next = remaining_time;
    pulses_left_next    = pulses_left;
    mode_next           = mode;
    pin_state_next      = pin_state;
    if (step) begin
      if (operation == OP_ARM) begin
        remaining_time_next = '0;
        pulses_left_next    = COUNT_BITS'(cfg.pulse_count);
        case (arm_mode)
          ARM_RUN:  mode_next = MODE_RUN;
          ARM_STOP: mode_next = MODE_STOP;
          default:  mode_next = MODE_RELEASE;
        endcase
      end else begin
        case (mode)
          MODE_RUN: begin
            remaining_time_next = rem_dec;
            if (rem_dec == '0) begin
              if (pulses_left != '0) begin
                pulses_left_next    = pulses_left - 1'b1;
                remaining_time_next = reload;
                pin_state_next      = PIN_ON;
              end else begin
                mode_next      = MODE_STOP;
                pin_state_next = PIN_OFF;
              end
            end else if (rem_dec <= off_ext) begin
              pin_state_next = PIN_OFF;
            end
          end
          MODE_STOP: begin
            mode_next      = MODE_RELEASE;
            pin_state_next = PIN_OFF;
          end
          default: begin
            pin_state_next = PIN_FREE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_time <= '0;
      pulses_left    <= '0;
      mode           <= MODE_RELEASE;
      pin_state      <= PIN_OFF;
    end else begin
      remaining_time <= remaining_time_next;
      pulses_left    <= pulses_left_next;
      mode           <= mode_next;
      pin_state      <= pin_state_next;
    end
  end

  assign pin_status = pin_state_next;
  assign running    = (mode_next == MODE_RUN);

`include "repeat_pulse_generator_top_assert.svh"

  `RPG_ASSERT_NEXT(a_arm_clears_time, step && operation == OP_ARM, remaining_time == '0)
  `RPG_ASSERT_NEXT(a_tick_never_adds_pulses, step && operation == OP_TICK, pulses_left <= $past(pulses_left))
  `RPG_ASSERT_NEXT(a_stop_goes_release, step && operation == OP_TICK && mode == MODE_STOP, mode == MODE_RELEASE && pin_state == PIN_OFF)
  `RPG_ASSERT_NEXT(a_release_is_free, step && operation == OP_TICK && mode == MODE_RELEASE, pin_state == PIN_FREE)

endmodule

// File: design/repeat_pulse_generator_top.sv
// Output: a result is registered and shown in the cycle after its input transfer.
// Throughput: one item per cycle while the result side does not stall; the single
// state register update in the core and the one-entry result register set this figure.
// Reset (rst, synchronous, active high) sets mode to release, pin off, timer and
// pulse count to zero, and registers to on 100, off 100, pulse count 2.
// ---------------------------------------------------------------------------
// Repeat pulse generator top level
// Stream ports, configuration registers and the result register.
// ---------------------------------------------------------------------------
module repeat_pulse_generator_top #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rpg_pkg::IN_TDATA_W-1:0]  s_tdata,   // elapsed[15:0], arm_mode[17:16], zero pad
  input  logic                            s_tuser,   // operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rpg_pkg::OUT_TDATA_W-1:0] m_tdata,   // pin_status[1:0], running[2], zero pad
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [rpg_pkg::CFG_W-1:0]       cfg_data
);
  import rpg_pkg::*;

  cfg_t  cfg;
  logic  step;
  pin_t  pin_status;
  logic  running;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_duration  <= CFG_W'(100);
      cfg.off_duration <= CFG_W'(100);
      cfg.pulse_count  <= CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ON_DURATION:  cfg.on_duration  <= cfg_data;
        REG_OFF_DURATION: cfg.off_duration <= cfg_data;
        REG_PULSE_COUNT:  cfg.pulse_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  rpg_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .operation  (s_tuser),
    .elapsed    (s_tdata[ELAPSED_W-1:0]),
    .arm_mode   (s_tdata[ELAPSED_W+1:ELAPSED_W]),
    .cfg        (cfg),
    .pin_status (pin_status),
    .running    (running)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {{(OUT_TDATA_W-3){1'b0}}, running, pin_status};
    end
  end

endmodule

// File: tb/rpg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Repeat pulse generator checker
// Watches the input, result and register channels of the pulse generator.
// It keeps its own model of the timer, pulse counter, mode and pin, and
// predicts one result for every input transfer. It compares each result
// transfer with the oldest prediction and counts the mismatches.
// ---------------------------------------------------------------------------
module rpg_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rpg_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rpg_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [rpg_pkg::CFG_W-1:0]       cfg_data,
  output int                              mismatch_count,
  output int                              results_owed
);
  import rpg_pkg::*;

  typedef struct {
    pin_t pin;
    logic running;
  } pin_report_t;

  cfg_t              regs;
  logic [CFG_W:0]    time_left;
  logic [CFG_W-1:0]  pulses_left;
  mode_t             gen_mode;
  pin_t              pin_now;
  pin_report_t       owed_reports[$];
  pin_report_t       oldest;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic pin_report_t advance_generator(logic op, logic [ELAPSED_W-1:0] elapsed,
                                                    logic [1:0] arm_mode);
    pin_report_t report;
    if (op == OP_ARM) begin
      time_left   = '0;
      pulses_left = regs.pulse_count;
      case (arm_mode)
        ARM_RUN:  gen_mode = MODE_RUN;
        ARM_STOP: gen_mode = MODE_STOP;
        default:  gen_mode = MODE_RELEASE;
      endcase
    end else begin
      case (gen_mode)
        MODE_RUN: begin
          if (time_left > elapsed) time_left = time_left - elapsed;
          else time_left = '0;
          if (time_left == 0) begin
            if (pulses_left != 0) begin
              pulses_left = pulses_left - 1'b1;
              time_left   = {1'b0, regs.on_duration} + {1'b0, regs.off_duration};
              pin_now     = PIN_ON;
            end else begin
              gen_mode = MODE_STOP;
              pin_now  = PIN_OFF;
            end
          end else if (time_left <= {1'b0, regs.off_duration}) begin
            pin_now = PIN_OFF;
          end
        end
        MODE_STOP: begin
          gen_mode = MODE_RELEASE;
          pin_now  = PIN_OFF;
        end
        default: pin_now = PIN_FREE;
      endcase
    end
    report.pin     = pin_now;
    report.running = (gen_mode == MODE_RUN);
    return report;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.on_duration  = 16'd100;
      regs.off_duration = 16'd100;
      regs.pulse_count  = 16'd2;
      time_left         = '0;
      pulses_left       = '0;
      gen_mode          = MODE_RELEASE;
      pin_now           = PIN_OFF;
      owed_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_reports.size() == 0) begin
          flag_mismatch("result with none expected", m_tdata, 0);
        end else begin
          oldest = owed_reports.pop_front();
          if (m_tdata[1:0] !== oldest.pin) flag_mismatch("pin_status", m_tdata[1:0], oldest.pin);
          if (m_tdata[2] !== oldest.running) flag_mismatch("running", m_tdata[2], oldest.running);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ON_DURATION:  regs.on_duration  = cfg_data;
          REG_OFF_DURATION: regs.off_duration = cfg_data;
          REG_PULSE_COUNT:  regs.pulse_count  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        owed_reports.push_back(advance_generator(s_tuser, s_tdata[ELAPSED_W-1:0],
                                                 s_tdata[ELAPSED_W+1:ELAPSED_W]));
    end
    results_owed = owed_reports.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Repeat pulse generator testbench
// Drives directed and random tick and arm transfers into the generator,
// rewrites the timing registers between phases, and varies the idle rates
// of both stream sides, including one long result stall. The checker beside
// the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
  import rpg_pkg::*;

  localparam logic [1:0] ARM_UNUSED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = REG_ON_DURATION;
  logic [CFG_W-1:0]        cfg_data = '0;

  int mismatch_count;
  int results_owed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int load_phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cur_on = 100;
  int cur_off = 100;

  repeat_pulse_generator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rpg_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // In the third phase the receiver refuses results for a long stretch so
  // that the result register fills and the input side stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (load_phase == 3 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic op, logic [ELAPSED_W-1:0] elapsed, logic [1:0] arm_mode);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W-ELAPSED_W-2){1'b0}}, arm_mode, elapsed};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int on_time, int off_time, int count);
    logic [1:0]       idx[3];
    logic [CFG_W-1:0] val[3];
    idx = '{REG_ON_DURATION, REG_OFF_DURATION, REG_PULSE_COUNT};
    val = '{on_time[CFG_W-1:0], off_time[CFG_W-1:0], count[CFG_W-1:0]};
    cur_on  = on_time;
    cur_off = off_time;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ELAPSED_W-1:0] clamp_time(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[ELAPSED_W-1:0];
  endfunction

  initial begin
    int         pick;
    int         on_time;
    int         off_time;
    int         count;
    logic       op;
    logic [1:0] arm_mode;
    logic [15:0] elapsed;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: release, stop, unused mode, then a full two-pulse train.
    send_item(OP_TICK, 16'd0, ARM_RUN);
    send_item(OP_ARM, 16'd0, ARM_STOP);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    send_item(OP_ARM, 16'hFFFF, ARM_UNUSED);
    send_item(OP_TICK, 16'd0, ARM_UNUSED);
    send_item(OP_ARM, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd50, ARM_RUN);
    send_item(OP_TICK, 16'd50, ARM_RUN);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    send_item(OP_TICK, 16'd0, ARM_RUN);
    drain_results();

    // Zero period with the largest pulse count.
    set_config(0, 0, 65535);
    send_item(OP_ARM, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    drain_results();

    // Longest period needs the extra timer bit.
    set_config(65535, 65535, 1);
    send_item(OP_ARM, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd1, ARM_RUN);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    send_item(OP_TICK, 16'hFFFF, ARM_RUN);
    drain_results();

    set_config(65535, 65535, 0);
    send_item(OP_ARM, 16'd0, ARM_RUN);
    send_item(OP_TICK, 16'd0, ARM_RUN);
    drain_results();

    for (int phase = 1; phase <= 3; phase++) begin
      load_phase    = phase;
      send_idle_pct = (phase == 1) ? 29 : (phase == 2) ? 52 : 0;
      recv_idle_pct = (phase == 1) ? 52 : (phase == 2) ? 29 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(5))
          0: begin on_time = 100; off_time = 100; count = 2; end
          1: begin
            on_time  = $urandom_range(1, 20);
            off_time = $urandom_range(1, 20);
            count    = $urandom_range(0, 5);
          end
          2: begin
            on_time  = $urandom_range(1) ? 0 : $urandom_range(1, 30);
            off_time = (on_time != 0) ? 0 : $urandom_range(0, 30);
            count    = $urandom_range(0, 6);
          end
          3: begin
            on_time  = $urandom_range(1) ? 65535 : 0;
            off_time = $urandom_range(1) ? 65535 : 0;
            count    = $urandom_range(0, 3);
          end
          4: begin
            on_time  = $urandom_range(65535);
            off_time = $urandom_range(65535);
            count    = $urandom_range(0, 8);
          end
          default: begin
            on_time  = $urandom_range(0, 12);
            off_time = $urandom_range(0, 12);
            count    = $urandom_range(1) ? 65535 : $urandom_range(65535);
          end
        endcase
        set_config(on_time, off_time, count);
        for (int n = 0; n < 112; n++) begin
          op   = ($urandom_range(99) < 8) ? OP_ARM : OP_TICK;
          pick = $urandom_range(99);
          if (op == OP_ARM)
            arm_mode = (pick < 60) ? ARM_RUN : (pick < 75) ? ARM_STOP :
                       (pick < 90) ? ARM_RELEASE : ARM_UNUSED;
          else
            arm_mode = 2'($urandom_range(3));
          pick = $urandom_range(99);
          if (pick < 10)      elapsed = '0;
          else if (pick < 15) elapsed = 16'hFFFF;
          else if (pick < 30) elapsed = 16'($urandom_range(65535));
          else if (pick < 55) elapsed = clamp_time($urandom_range(0, (cur_on + cur_off) / 3 + 1));
          else if (pick < 80) elapsed = clamp_time(cur_off + $urandom_range(0, 4) - 2);
          else                elapsed = clamp_time(cur_on + $urandom_range(0, 4) - 2);
          send_item(op, elapsed, arm_mode);
        end
        drain_results();
      end
    end

    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
